// ===== rtl/cbd_pkg.sv =====
// Package for the cell balance discharge controller: widths, codes,
// payload and configuration structs. Depends on nothing.
`timescale 1ns / 1ps
package cbd_pkg;

	localparam int MV_W      = 13;
	localparam int BYTE_W    = 8;
	localparam int BLEED_W   = 8;
	localparam int CELLS_W   = 4;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 3;

	// input commands
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PRESS  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CELL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CELL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STORAGE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FINISH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd5;

	// register reset values
	localparam logic [MV_W-1:0]   RST_PRESENCE = 13'd3000;
	localparam logic [MV_W-1:0]   RST_MIN_CELL = 13'd3000;
	localparam logic [MV_W-1:0]   RST_MAX_CELL = 13'd4300;
	localparam logic [MV_W-1:0]   RST_STORAGE  = 13'd3800;
	localparam logic [BYTE_W-1:0] RST_FINISH   = 8'd3;
	localparam logic [BYTE_W-1:0] RST_PERIOD   = 8'd30;

	localparam logic [BYTE_W-1:0] QUIET_MAX = 8'd255;

	typedef enum logic [STATUS_W-1:0] {
		PH_INIT  = 2'd0,
		PH_RUN   = 2'd1,
		PH_DONE  = 2'd2,
		PH_FAULT = 2'd3
	} phase_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [MV_W-1:0]  cell_voltage_mv;
	} cbd_in_t;

	typedef struct packed {
		logic [BLEED_W-1:0]  bleed_mask;
		logic [STATUS_W-1:0] run_status;
		logic                balance_on;
		logic [MV_W-1:0]     target_mv;
		logic [CELLS_W-1:0]  cells_present;
		logic                round_request;
		logic                round_end;
	} cbd_out_t;

	typedef struct packed {
		logic [MV_W-1:0]   presence_threshold_mv;
		logic [MV_W-1:0]   min_cell_mv;
		logic [MV_W-1:0]   max_cell_mv;
		logic [MV_W-1:0]   storage_target_mv;
		logic [BYTE_W-1:0] finish_rounds;
		logic [BYTE_W-1:0] period_seconds;
	} cbd_cfg_t;

endpackage

// ===== rtl/cbd_cfg_regs.sv =====
// Configuration register file of the discharge controller.
// Depends on cbd_pkg for register indexes, reset values and cbd_cfg_t.
`timescale 1ns / 1ps
module cbd_cfg_regs
	import cbd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [CFG_IDX_W-1:0] index,
	input  logic [MV_W-1:0]      data,
	output cbd_cfg_t             cfg
);

	cbd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.presence_threshold_mv <= RST_PRESENCE;
			cfg_q.min_cell_mv           <= RST_MIN_CELL;
			cfg_q.max_cell_mv           <= RST_MAX_CELL;
			cfg_q.storage_target_mv     <= RST_STORAGE;
			cfg_q.finish_rounds         <= RST_FINISH;
			cfg_q.period_seconds        <= RST_PERIOD;
		end else if (we) begin
			case (index)
				REG_PRESENCE: cfg_q.presence_threshold_mv <= data;
				REG_MIN_CELL: cfg_q.min_cell_mv           <= data;
				REG_MAX_CELL: cfg_q.max_cell_mv           <= data;
				REG_STORAGE:  cfg_q.storage_target_mv     <= data;
				REG_FINISH:   cfg_q.finish_rounds         <= data[BYTE_W-1:0];
				REG_PERIOD:   cfg_q.period_seconds        <= data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/cell_balance_discharge_controller_core.sv =====
// Each accepted item is held in the input register; its result is then
// written to the result register, which holds it back while the output stalls.
// Throughput: one item per cycle while the result is taken; the whole state update is one
// compare-and-select pass between the two registers.
// Reset (arst_n low, asynchronous): initial-measure phase, balance mode,
// registers at their documented defaults, both pipeline stages empty.
`timescale 1ns / 1ps
module cell_balance_discharge_controller_core
	import cbd_pkg::*;
#(
	parameter int CELL_SLOTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cbd_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cbd_out_t             out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MV_W-1:0]      cfg_data
);

	localparam int IDX_W = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
	localparam int CNT_W = $clog2(CELL_SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELL_SLOTS - 1);

	cbd_cfg_t cfg;

	cbd_cfg_regs u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.index (cfg_index),
		.data  (cfg_data),
		.cfg   (cfg)
	);

	// pipeline stages
	cbd_in_t  in_s1;
	logic     in_valid_s1;
	cbd_out_t res_s2;
	logic     res_valid_s2;
	logic     advance;

	// controller state
	phase_t                phase_q;
	logic                  balance_q;
	logic                  retarget_q;
	logic [MV_W-1:0]       target_q;
	logic [CNT_W-1:0]      cell_total_q;
	logic [BYTE_W-1:0]     tick_q;
	logic [BYTE_W-1:0]     quiet_q;
	logic [CELL_SLOTS-1:0] bleed_q;
	logic [MV_W-1:0]       round_min_q;
	logic [IDX_W-1:0]      sample_idx_q;
	logic                  counting_q;
	logic                  round_bled_q;

	// next state
	phase_t                phase_d;
	logic                  balance_d;
	logic                  retarget_d;
	logic [MV_W-1:0]       target_d;
	logic [CNT_W-1:0]      cell_total_d;
	logic [BYTE_W-1:0]     tick_d;
	logic [BYTE_W-1:0]     quiet_d;
	logic [CELL_SLOTS-1:0] bleed_d;
	logic [MV_W-1:0]       round_min_d;
	logic [IDX_W-1:0]      sample_idx_d;
	logic                  counting_d;
	logic                  round_bled_d;
	logic                  req;
	logic                  rend;
	logic                  fault_hit;
	logic                  retarget_round;
	logic [MV_W-1:0]       v;
	logic [BLEED_W-1:0]    mask;
	cbd_out_t              res;

	assign advance  = in_valid_s1 && (!res_valid_s2 || out_ready);
	assign in_ready = !in_valid_s1 || advance;

	always_comb begin
		phase_d        = phase_q;
		balance_d      = balance_q;
		retarget_d     = retarget_q;
		target_d       = target_q;
		cell_total_d   = cell_total_q;
		tick_d         = tick_q;
		quiet_d        = quiet_q;
		bleed_d        = bleed_q;
		round_min_d    = round_min_q;
		sample_idx_d   = sample_idx_q;
		counting_d     = counting_q;
		round_bled_d   = round_bled_q;
		req            = 1'b0;
		rend           = 1'b0;
		fault_hit      = 1'b0;
		v              = in_s1.cell_voltage_mv;
		retarget_round = retarget_q && balance_q;
		mask           = '0;

		case (in_s1.cmd)
			CMD_SAMPLE: begin
				if (phase_q == PH_INIT || phase_q == PH_RUN) begin
					// first sample opens a fresh round
					if (sample_idx_q == '0) begin
						round_min_d  = cfg.max_cell_mv;
						counting_d   = 1'b1;
						round_bled_d = 1'b0;
						bleed_d      = '0;
					end
					if (phase_q == PH_INIT) begin
						if (counting_d) begin
							if (v < cfg.presence_threshold_mv) begin
								counting_d = 1'b0;
							end else begin
								cell_total_d = CNT_W'(sample_idx_q) + CNT_W'(1);
								if (v < round_min_d)
									round_min_d = v;
							end
						end
					end else if (CNT_W'(sample_idx_q) < cell_total_q) begin
						if (retarget_round) begin
							if (v < round_min_d)
								round_min_d = v;
						end else if (v < cfg.min_cell_mv || v >= cfg.max_cell_mv) begin
							fault_hit    = 1'b1;
							phase_d      = PH_FAULT;
							bleed_d      = '0;
							sample_idx_d = '0;
						end else if (v > target_q) begin
							bleed_d      = bleed_d | (CELL_SLOTS'(1) << sample_idx_q);
							round_bled_d = 1'b1;
						end
					end
					if (!fault_hit) begin
						if (sample_idx_q != LAST_IDX) begin
							sample_idx_d = sample_idx_q + IDX_W'(1);
						end else begin
							sample_idx_d = '0;
							rend         = 1'b1;
							if (phase_q == PH_INIT) begin
								target_d = round_min_d;
								phase_d  = PH_RUN;
								tick_d   = '0;
								req      = 1'b1;
							end else if (retarget_round) begin
								target_d   = round_min_d;
								retarget_d = 1'b0;
								req        = 1'b1;
							end else begin
								if (round_bled_d)
									quiet_d = '0;
								else if (quiet_q != QUIET_MAX)
									quiet_d = quiet_q + BYTE_W'(1);
								if (quiet_d >= cfg.finish_rounds) begin
									phase_d = PH_DONE;
									bleed_d = '0;
								end
							end
						end
					end
				end
			end
			CMD_TICK: begin
				if (phase_q == PH_RUN) begin
					tick_d = tick_q + BYTE_W'(1);
					if (tick_d >= cfg.period_seconds) begin
						tick_d = '0;
						req    = 1'b1;
					end
				end
			end
			CMD_PRESS: begin
				if (phase_q == PH_RUN) begin
					// abort the partial round and switch mode
					balance_d    = !balance_q;
					sample_idx_d = '0;
					round_min_d  = cfg.max_cell_mv;
					counting_d   = 1'b1;
					round_bled_d = 1'b0;
					bleed_d      = '0;
					tick_d       = '0;
					req          = 1'b1;
					retarget_d   = balance_d;
					if (!balance_d)
						target_d = cfg.storage_target_mv;
				end
			end
			default: ;
		endcase

		if (phase_d == PH_INIT && sample_idx_d == '0)
			req = 1'b1;

		if (phase_d == PH_RUN && sample_idx_d == '0)
			mask[CELL_SLOTS-1:0] = bleed_d;

		res.bleed_mask    = mask;
		res.run_status    = phase_d;
		res.balance_on    = balance_d;
		res.target_mv     = target_d;
		res.cells_present = CELLS_W'(cell_total_d);
		res.round_request = req;
		res.round_end     = rend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				in_valid_s1 <= in_valid;
			if (advance)
				res_valid_s2 <= 1'b1;
			else if (out_ready)
				res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			in_s1 <= in_data;
		if (advance)
			res_s2 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_INIT;
			balance_q    <= 1'b1;
			retarget_q   <= 1'b0;
			target_q     <= '0;
			cell_total_q <= '0;
			tick_q       <= '0;
			quiet_q      <= '0;
			bleed_q      <= '0;
			round_min_q  <= RST_MAX_CELL;
			sample_idx_q <= '0;
			counting_q   <= 1'b1;
			round_bled_q <= 1'b0;
		end else if (advance) begin
			phase_q      <= phase_d;
			balance_q    <= balance_d;
			retarget_q   <= retarget_d;
			target_q     <= target_d;
			cell_total_q <= cell_total_d;
			tick_q       <= tick_d;
			quiet_q      <= quiet_d;
			bleed_q      <= bleed_d;
			round_min_q  <= round_min_d;
			sample_idx_q <= sample_idx_d;
			counting_q   <= counting_d;
			round_bled_q <= round_bled_d;
		end
	end

	assign out_valid = res_valid_s2;
	assign out_data  = res_s2;

`ifndef SYNTHESIS
	// finished and fault are only left by reset
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("finished phase left");

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FAULT |=> phase_q == PH_FAULT)
		else $error("fault phase left");

	// cell count frozen once the first round is over
	a_count_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_INIT |=> $stable(cell_total_q))
		else $error("cell count changed after initial round");

	// bleeding only reported while running
	a_bleed_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.bleed_mask != '0 |-> res_s2.run_status == PH_RUN)
		else $error("bleed mask outside running phase");
`endif

endmodule

// ===== tb/tb_cell_balance_discharge_controller_core.sv =====
// Self-checking bench for the cell balance discharge controller core: a directed
// table, then three random phases with shifting idle patterns and a closing sequence.
// Depends on cbd_pkg and cell_balance_discharge_controller_core.
`timescale 1ns / 1ps
module tb_cell_balance_discharge_controller_core;
	import cbd_pkg::*;

	localparam int CELL_SLOTS  = 8;
	localparam int HOLD_CYCLES = 150;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 560;

	localparam logic [CMD_W-1:0]     CMD_NONE      = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	typedef struct {
		cbd_in_t  item;
		bit       typed;
		cbd_out_t want;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	cbd_in_t              in_data;
	logic                 out_valid;
	logic                 out_ready;
	cbd_out_t             out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MV_W-1:0]      cfg_data;

	// predictor copy of the block
	cbd_cfg_t           regs;
	phase_t             ph;
	logic               bal_mode, retarget, counting, any_bleed, calm_round;
	logic [MV_W-1:0]    tgt, low_mv;
	logic [CELLS_W-1:0] ncells, slot;
	logic [BYTE_W-1:0]  ticks, quiet;
	logic [BLEED_W-1:0] bleed;

	cbd_out_t pending_status [$];
	int       mismatches = 0;
	int       items_sent = 0;
	int       results_seen = 0;
	int       rounds_closed = 0;
	int       rounds_bled = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	bit       squeeze_ask = 0;
	int       hold_left = 0;
	int       stall_cycles = 0;

	cell_balance_discharge_controller_core #(
		.CELL_SLOTS(CELL_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic cbd_out_t status_word(logic [BLEED_W-1:0] b, phase_t p, logic m,
			logic [MV_W-1:0] t, logic [CELLS_W-1:0] n, logic rq, logic fin);
		cbd_out_t w;
		w.bleed_mask    = b;
		w.run_status    = p;
		w.balance_on    = m;
		w.target_mv     = t;
		w.cells_present = n;
		w.round_request = rq;
		w.round_end     = fin;
		return w;
	endfunction

	function automatic row_t row(logic [CMD_W-1:0] c, logic [MV_W-1:0] v,
			bit typed = 1'b0, cbd_out_t want = '0);
		row_t r;
		r.item.cmd = c;
		r.item.cell_voltage_mv = v;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic void open_round();
		low_mv = regs.max_cell_mv;
		counting = 1'b1;
		any_bleed = 1'b0;
		bleed = '0;
	endfunction

	// advances the predictor by one item and returns the status it should report
	function automatic cbd_out_t predict_status(cbd_in_t it);
		logic            req, fin, faulted;
		logic [MV_W-1:0] v;
		cbd_out_t        r;
		req = 1'b0;
		fin = 1'b0;
		faulted = 1'b0;
		v = it.cell_voltage_mv;
		case (it.cmd)
			CMD_SAMPLE: if (ph == PH_INIT || ph == PH_RUN) begin
				if (slot == 0)
					open_round();
				if (ph == PH_INIT) begin
					if (counting) begin
						if (v < regs.presence_threshold_mv) begin
							counting = 1'b0;
						end else begin
							ncells = slot + 4'd1;
							if (v < low_mv)
								low_mv = v;
						end
					end
				end else if (slot < ncells) begin
					if (retarget && bal_mode) begin
						if (v < low_mv)
							low_mv = v;
					end else if (v < regs.min_cell_mv || v >= regs.max_cell_mv) begin
						ph = PH_FAULT;
						bleed = '0;
						slot = '0;
						faulted = 1'b1;
					end else if (v > tgt) begin
						bleed[slot] = 1'b1;
						any_bleed = 1'b1;
					end
				end
				if (!faulted) begin
					if (slot != CELL_SLOTS - 1) begin
						slot = slot + 4'd1;
					end else begin
						slot = '0;
						fin = 1'b1;
						if (ph == PH_INIT) begin
							tgt = low_mv;
							ph = PH_RUN;
							ticks = '0;
							req = 1'b1;
						end else if (retarget && bal_mode) begin
							tgt = low_mv;
							retarget = 1'b0;
							req = 1'b1;
						end else begin
							if (any_bleed)
								quiet = '0;
							else if (quiet != QUIET_MAX)
								quiet = quiet + 8'd1;
							if (quiet >= regs.finish_rounds) begin
								ph = PH_DONE;
								bleed = '0;
							end
						end
					end
				end
			end
			CMD_TICK: if (ph == PH_RUN) begin
				ticks = ticks + 8'd1;
				if (ticks >= regs.period_seconds) begin
					ticks = '0;
					req = 1'b1;
				end
			end
			CMD_PRESS: if (ph == PH_RUN) begin
				bal_mode = !bal_mode;
				slot = '0;
				open_round();
				ticks = '0;
				req = 1'b1;
				if (bal_mode) begin
					retarget = 1'b1;
				end else begin
					retarget = 1'b0;
					tgt = regs.storage_target_mv;
				end
			end
			default: ;
		endcase
		if (ph == PH_INIT && slot == 0)
			req = 1'b1;
		r = status_word((ph == PH_RUN && slot == 0) ? bleed : '0, ph, bal_mode, tgt, ncells,
			req, fin);
		return r;
	endfunction

	// voltage for the next sample: legal for counted cells unless a retarget round
	// lets it stray; a calm round keeps each counted cell at or under the target if that is not below the minimum
	function automatic logic [MV_W-1:0] pick_cell_mv(bit calm_only);
		int lo, hi, top;
		lo = regs.min_cell_mv;
		hi = int'(regs.max_cell_mv) - 1;
		if (hi < lo)
			hi = lo;
		if (slot == 0)
			calm_round = calm_only || ($urandom_range(0, 5) == 0);
		if (slot >= ncells)
			return MV_W'($urandom_range(0, 8191));
		if (retarget && bal_mode && $urandom_range(0, 3) == 0)
			return MV_W'($urandom_range(0, 8191));
		top = (int'(tgt) < hi) ? int'(tgt) : hi;
		if (calm_round && top >= lo)
			return MV_W'($urandom_range(lo, top));
		case ($urandom_range(0, 7))
			0: return MV_W'(lo);
			1: return MV_W'(hi);
			2: return MV_W'((top >= lo) ? top : hi);
			default: return MV_W'($urandom_range(lo, hi));
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic check_status(cbd_out_t got);
		cbd_out_t want;
		if (pending_status.size() == 0) begin
			report_mismatch($sformatf("result %h with nothing pending", got));
			return;
		end
		want = pending_status.pop_front();
		results_seen++;
		if (got.round_end) begin
			rounds_closed++;
			if (got.bleed_mask != 0)
				rounds_bled++;
		end
		if (got.bleed_mask !== want.bleed_mask)
			report_mismatch($sformatf("bleed_mask got %h want %h", got.bleed_mask,
				want.bleed_mask));
		if (got.run_status !== want.run_status)
			report_mismatch($sformatf("run_status got %0d want %0d", got.run_status,
				want.run_status));
		if (got.balance_on !== want.balance_on)
			report_mismatch($sformatf("balance_on got %b want %b", got.balance_on,
				want.balance_on));
		if (got.target_mv !== want.target_mv)
			report_mismatch($sformatf("target_mv got %0d want %0d", got.target_mv,
				want.target_mv));
		if (got.cells_present !== want.cells_present)
			report_mismatch($sformatf("cells_present got %0d want %0d", got.cells_present,
				want.cells_present));
		if (got.round_request !== want.round_request)
			report_mismatch($sformatf("round_request got %b want %b", got.round_request,
				want.round_request));
		if (got.round_end !== want.round_end)
			report_mismatch($sformatf("round_end got %b want %b", got.round_end,
				want.round_end));
	endtask

	// called on a clock step; returns on the step the item is taken
	task automatic push_item(cbd_in_t it, bit typed, cbd_out_t want);
		cbd_out_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		predicted = predict_status(it);
		pending_status.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MV_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_PRESENCE: regs.presence_threshold_mv = val;
			REG_MIN_CELL: regs.min_cell_mv = val;
			REG_MAX_CELL: regs.max_cell_mv = val;
			REG_STORAGE:  regs.storage_target_mv = val;
			REG_FINISH:   regs.finish_rounds = val[BYTE_W-1:0];
			REG_PERIOD:   regs.period_seconds = val[BYTE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [MV_W-1:0] presence, logic [MV_W-1:0] lo_mv,
			logic [MV_W-1:0] hi_mv, logic [MV_W-1:0] store_mv, logic [MV_W-1:0] finish,
			logic [MV_W-1:0] period);
		write_reg(REG_PRESENCE, presence);
		write_reg(REG_MIN_CELL, lo_mv);
		write_reg(REG_MAX_CELL, hi_mv);
		write_reg(REG_STORAGE, store_mv);
		write_reg(REG_FINISH, finish);
		write_reg(REG_PERIOD, period);
		cfg_we <= 1'b0;
	endtask

	// stop offering and let every expected item drain before touching the registers
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_traffic(int count);
		cbd_in_t it;
		int      roll;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			it.cell_voltage_mv = MV_W'($urandom_range(0, 8191));
			if (roll < 80) begin
				it.cmd = CMD_SAMPLE;
				it.cell_voltage_mv = pick_cell_mv(1'b0);
			end else if (roll < 90) begin
				it.cmd = CMD_TICK;
			end else if (roll < 96) begin
				it.cmd = CMD_PRESS;
			end else begin
				it.cmd = CMD_NONE;
			end
			push_item(it, 1'b0, '0);
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_status(out_data);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (squeeze_ask) begin
				// long hold-off so the pipeline fills and back-pressures the input
				squeeze_ask = 1'b0;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		row_t     script [23];
		cbd_out_t idle_init;
		cbd_in_t  it;
		int       k;
		int       bad_slot;
		int       floor_mv;
		bit       pressed;
		bit       end_in_fault;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		regs.presence_threshold_mv = RST_PRESENCE;
		regs.min_cell_mv = RST_MIN_CELL;
		regs.max_cell_mv = RST_MAX_CELL;
		regs.storage_target_mv = RST_STORAGE;
		regs.finish_rounds = RST_FINISH;
		regs.period_seconds = RST_PERIOD;
		ph = PH_INIT;
		bal_mode = 1'b1;
		retarget = 1'b0;
		tgt = '0;
		ncells = '0;
		ticks = '0;
		quiet = '0;
		bleed = '0;
		low_mv = RST_MAX_CELL;
		slot = '0;
		counting = 1'b1;
		any_bleed = 1'b0;
		calm_round = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// spare indexes must leave the defaults alone
		write_reg(REG_UNUSED_LO, 13'h1FFF);
		write_reg(REG_UNUSED_HI, 13'h0000);
		cfg_we <= 1'b0;

		send_idle_pct = 18;
		recv_idle_pct = 81;

		idle_init = status_word(8'd0, PH_INIT, 1'b1, 13'd0, 4'd0, 1'b1, 1'b0);
		// first round: seven cells counted, 2999 ends the string, lowest is 3000;
		// check round bleeds cells 0, 2, 3 and 6; then a press either way
		script = '{
			row(CMD_NONE,   13'd8191, 1'b1, idle_init),
			row(CMD_TICK,   13'd0,    1'b1, idle_init),
			row(CMD_PRESS,  13'd4096, 1'b1, idle_init),
			row(CMD_SAMPLE, 13'd4000, 1'b1,
				status_word(8'd0, PH_INIT, 1'b1, 13'd0, 4'd1, 1'b0, 1'b0)),
			row(CMD_SAMPLE, 13'd3500),
			row(CMD_SAMPLE, 13'd8191),
			row(CMD_SAMPLE, 13'd3900),
			row(CMD_SAMPLE, 13'd4299),
			row(CMD_SAMPLE, 13'd3000),
			row(CMD_SAMPLE, 13'd3700),
			row(CMD_SAMPLE, 13'd2999, 1'b1,
				status_word(8'd0, PH_RUN, 1'b1, 13'd3000, 4'd7, 1'b1, 1'b1)),
			row(CMD_SAMPLE, 13'd3001),
			row(CMD_SAMPLE, 13'd3000),
			row(CMD_SAMPLE, 13'd4299),
			row(CMD_SAMPLE, 13'd3500),
			row(CMD_SAMPLE, 13'd3000),
			row(CMD_SAMPLE, 13'd3000),
			row(CMD_SAMPLE, 13'd4000),
			row(CMD_SAMPLE, 13'd8191, 1'b1,
				status_word(8'd77, PH_RUN, 1'b1, 13'd3000, 4'd7, 1'b0, 1'b1)),
			row(CMD_TICK,   13'd0),
			row(CMD_PRESS,  13'd0,    1'b1,
				status_word(8'd0, PH_RUN, 1'b0, 13'd3800, 4'd7, 1'b1, 1'b0)),
			row(CMD_PRESS,  13'd0,    1'b1,
				status_word(8'd0, PH_RUN, 1'b1, 13'd3800, 4'd7, 1'b1, 1'b0)),
			row(CMD_NONE,   13'h1555)
		};
		for (k = 0; k < 23; k++)
			push_item(script[k].item, script[k].typed, script[k].want);
		settle();

		// widest legal window, every tick requests a round
		set_regs(13'd0, 13'd0, 13'd8191, 13'd0, 13'd255, 13'd1);
		random_traffic(PHASE_ITEMS);
		settle();

		// finish and period written with upper bits set to check masking
		send_idle_pct = 81;
		recv_idle_pct = 18;
		set_regs(13'd8191, 13'd3000, 13'd4300, 13'd8191, 13'h1FFF, 13'h1FFF);
		random_traffic(PHASE_ITEMS);
		settle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		floor_mv = $urandom_range(0, 4000);
		set_regs(MV_W'($urandom_range(0, 8191)), MV_W'(floor_mv),
			MV_W'($urandom_range(floor_mv + 1, 8191)), MV_W'($urandom_range(0, 8191)),
			13'd255, 13'd0);
		squeeze_ask = 1'b1;
		random_traffic(PHASE_ITEMS);
		settle();

		// closing: storage mode, then a round that either faults or finishes at once
		set_regs(13'd3000, 13'd3000, 13'd4300, 13'd3800, 13'd0, 13'd30);
		end_in_fault = $urandom_range(0, 1);
		pressed = 1'b0;
		while (ph == PH_RUN && (!pressed || bal_mode)) begin
			it.cmd = CMD_PRESS;
			it.cell_voltage_mv = MV_W'($urandom_range(0, 8191));
			push_item(it, 1'b0, '0);
			pressed = 1'b1;
		end
		bad_slot = (ncells == 0) ? 0 : $urandom_range(0, int'(ncells) - 1);
		for (k = 0; k < CELL_SLOTS; k++) begin
			it.cmd = CMD_SAMPLE;
			if (end_in_fault && k == bad_slot) begin
				case ($urandom_range(0, 3))
					0: it.cell_voltage_mv = regs.min_cell_mv - 13'd1;
					1: it.cell_voltage_mv = regs.max_cell_mv;
					2: it.cell_voltage_mv = 13'd0;
					default: it.cell_voltage_mv = 13'd8191;
				endcase
			end else begin
				it.cell_voltage_mv = pick_cell_mv(1'b1);
			end
			push_item(it, 1'b0, '0);
		end
		// the end is sticky: everything after it must be ignored
		repeat (24) begin
			it.cmd = CMD_W'($urandom_range(0, 3));
			it.cell_voltage_mv = MV_W'($urandom_range(0, 8191));
			push_item(it, 1'b0, '0);
		end
		settle();

		$display("Run drove %0d items and checked %0d results; %0d rounds closed, %0d bleeding.",
			items_sent, results_seen, rounds_closed, rounds_bled);
		$display("Closing sequence left the block in %s.", ph.name());
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
